>>> sv/bus_pkg.sv
`default_nettype none

package bus_pkg;

  // Field widths
  localparam int KEY_W = 32;
  localparam int CNT_W = 8;
  localparam int ST_W  = 2;

  // Request kinds carried on in_tuser
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_DUP      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch request, restart scan
    logic scan;    // step the key scan / compaction
    logic commit;  // update count, write key, load result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // all held entries compared, no read in flight
    logic full_add;   // add request with count at or above the limit
    logic out_busy;   // result register holds an untaken result
  } sts_t;

endpackage

`default_nettype wire

>>> sv/bus_ram.sv
`default_nettype none

module bus_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> sv/bus_ctrl.sv
`default_nettype none

module bus_ctrl
  import bus_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.full_add || sts.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN: begin
        cmd.scan = !sts.full_add;
      end
      S_COMMIT: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/bus_dp.sv
`default_nettype none

module bus_dp
  import bus_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [CNT_W-1:0] cfg_wr_data,
  input  wire logic             req_type,
  input  wire logic [KEY_W-1:0] req_key,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ST_W-1:0]       out_status,
  output logic [CNT_W-1:0]      out_count
);

  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CAP_MAX = (ENTRIES > 255) ? 255 : ENTRIES;

  logic [CNT_W-1:0] capacity_r;
  logic [CNT_W-1:0] held_count_r;
  logic             type_r;
  logic [KEY_W-1:0] key_r;
  logic [CNT_W-1:0] idx_r;
  logic             rd_vld_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic             found_r;
  logic             out_valid_r;
  logic [ST_W-1:0]  out_status_r;
  logic [CNT_W-1:0] out_count_r;

  logic [CNT_W-1:0] limit;
  logic             issue;
  logic             hit;
  logic             shift_we;
  logic             add_ok;
  logic             rem_ok;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [KEY_W-1:0] ram_rdata;
  logic [ST_W-1:0]  res_status;

  // Effective capacity: register value clipped to the store depth, or to 255 if that is smaller
  assign limit = (capacity_r > CNT_W'(CAP_MAX)) ? CNT_W'(CAP_MAX) : capacity_r;

  // Scan control: one read per cycle, compared in the cycle after it is issued
  assign issue    = cmd.scan && (idx_r < held_count_r);
  assign hit      = rd_vld_r && (ram_rdata == key_r);
  // On a remove, once the key is found, every later entry moves down one slot
  assign shift_we = cmd.scan && rd_vld_r && found_r && (type_r == REQ_REMOVE);

  assign add_ok = cmd.commit && (type_r == REQ_ADD) && !sts.full_add && !found_r;
  assign rem_ok = cmd.commit && (type_r == REQ_REMOVE) && found_r;

  // Result status
  always_comb begin
    if (type_r == REQ_ADD) begin
      if (held_count_r >= limit) res_status = ST_FULL;
      else if (found_r)          res_status = ST_DUP;
      else                       res_status = ST_OK;
    end else begin
      res_status = found_r ? ST_OK : ST_NOTFOUND;
    end
  end

  // Key store write port
  assign ram_we    = shift_we || add_ok;
  assign ram_waddr = add_ok ? AW'(held_count_r) : AW'(rd_idx_r - CNT_W'(1));
  assign ram_wdata = add_ok ? key_r : ram_rdata;

  bus_ram #(
    .WIDTH (KEY_W),
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(idx_r)),
    .rdata (ram_rdata)
  );

  // Capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= '0;
    end else if (cfg_wr_en) begin
      capacity_r <= cfg_wr_data;
    end
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r <= req_type;
      key_r  <= req_key;
    end
  end

  // Scan pointer, read tracking and match flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      rd_idx_r <= '0;
      found_r  <= 1'b0;
    end else if (cmd.load) begin
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (cmd.scan) begin
      if (issue) idx_r <= idx_r + CNT_W'(1);
      rd_vld_r <= issue;
      rd_idx_r <= idx_r;
      if (hit) found_r <= 1'b1;
    end
  end

  // Held count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= '0;
    end else if (add_ok) begin
      held_count_r <= held_count_r + CNT_W'(1);
    end else if (rem_ok) begin
      held_count_r <= held_count_r - CNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      if (add_ok)      out_count_r <= held_count_r + CNT_W'(1);
      else if (rem_ok) out_count_r <= held_count_r - CNT_W'(1);
      else             out_count_r <= held_count_r;
    end
  end

  assign sts.scan_done = (idx_r >= held_count_r) && !rd_vld_r;
  assign sts.full_add  = (type_r == REQ_ADD) && (held_count_r >= limit);
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count_r <= CNT_W'(CAP_MAX))
    else $error("held count above store depth");

  a_add_inc: assert property (@(posedge clk) disable iff (!rst_n)
    add_ok |=> held_count_r == $past(held_count_r) + CNT_W'(1))
    else $error("accepted add did not bump the count");

  a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !rd_vld_r && !shift_we)
    else $error("commit while a scan read is in flight");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    shift_we |-> (rd_idx_r != '0) && (rd_idx_r < held_count_r))
    else $error("compaction write outside held entries");

  a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_ready))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

>>> sv/bounded_unique_set.sv
// Flow: a request runs S_SCAN, then S_COMMIT loads the result behind out_tvalid; the
// scan reads one key RAM entry per cycle (none when the set is empty or an add is full).
// A new request is taken only in S_IDLE, after that load, which waits while a result
// waits for out_tready; remove compaction runs inside the scan pass.
// Reset (rst_n low, synchronous): count and capacity clear to zero, no result pending;
// the key RAM is not cleared, entries at or above the count are never read.
`default_nettype none

module bounded_unique_set
  import bus_pkg::*;
#(
  parameter int ENTRIES = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Config: capacity
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // Request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] member_key
  input  wire logic        in_tuser,   // [0] req_type
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [1:0] status, [9:2] count, [15:10] zero
);

  cmd_t             cmd;
  sts_t             sts;
  logic [ST_W-1:0]  res_status;
  logic [CNT_W-1:0] res_count;

  bus_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bus_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_type    (in_tuser),
    .req_key     (in_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (res_status),
    .out_count   (res_count)
  );

  assign out_tdata = {6'd0, res_count, res_status};

endmodule

`default_nettype wire

>>> bench/tb_bounded_unique_set.sv
`timescale 1ns / 1ps

module tb_bounded_unique_set;
  import bus_pkg::*;

  localparam int SLOTS = 128;
  localparam int POOL  = 64;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count;
  } answer_t;

  // Shadow copy of the key set; predicts status and count for each request
  class key_set_tracker;
    logic [KEY_W-1:0] held_keys[$];
    int unsigned      cap_limit;
    answer_t          expected_answers[$];
    int unsigned      mismatches;
    int unsigned      adds;
    int unsigned      removes;
    int unsigned      peak;
    int unsigned      by_status[4];

    // capacity above the slot count is clipped to the slot count
    function void set_capacity(logic [7:0] value);
      cap_limit = (value < SLOTS) ? value : SLOTS;
    endfunction

    function int find_key(logic [KEY_W-1:0] key);
      foreach (held_keys[i]) if (held_keys[i] == key) return i;
      return -1;
    endfunction

    function int unsigned pending();
      return expected_answers.size();
    endfunction

    function void note_request(logic req, logic [KEY_W-1:0] key);
      answer_t ans;
      int      pos;
      pos = find_key(key);
      if (req == REQ_ADD) begin
        adds++;
        // room is checked before the duplicate check
        if (held_keys.size() >= cap_limit) ans.status = ST_FULL;
        else if (pos >= 0) ans.status = ST_DUP;
        else begin
          held_keys.push_back(key);
          ans.status = ST_OK;
        end
      end else begin
        removes++;
        if (pos < 0) ans.status = ST_NOTFOUND;
        else begin
          held_keys.delete(pos);  // later keys close the gap
          ans.status = ST_OK;
        end
      end
      ans.count = CNT_W'(held_keys.size());
      if (ans.count > peak) peak = ans.count;
      by_status[ans.status]++;
      expected_answers.push_back(ans);
    endfunction

    function void check_result(logic [15:0] word);
      answer_t want;
      if (expected_answers.size() == 0) begin
        $display("%0t: result 0x%04h arrived with no request pending", $time, word);
        mismatches++;
        return;
      end
      want = expected_answers.pop_front();
      if (word[ST_W-1:0] !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, word[ST_W-1:0]);
        mismatches++;
      end
      if (word[ST_W +: CNT_W] !== want.count) begin
        $display("%0t: count mismatch, expected %0d, actual %0d",
                 $time, want.count, word[ST_W +: CNT_W]);
        mismatches++;
      end
      if (word[15:ST_W+CNT_W] !== '0) begin
        $display("%0t: pad bits mismatch, expected 0x00, actual 0x%02h",
                 $time, word[15:ST_W+CNT_W]);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] member_key
  logic        in_tuser = 1'b0; // [0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [1:0] status, [9:2] count, [15:10] zero

  key_set_tracker   board = new();
  logic [KEY_W-1:0] key_pool[POOL];
  bit               no_stall = 1'b0;
  int unsigned      settings = 0;

  bounded_unique_set #(.ENTRIES(SLOTS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check accepted results, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    out_tready <= no_stall || ($urandom_range(99) >= 17);
  end

  // Run limit
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_request(logic req, logic [KEY_W-1:0] key);
    while (!no_stall && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= req;
    do @(posedge clk); while (!in_tready);
    board.note_request(req, key);
  endtask

  // Capacity changes only with nothing in flight
  task automatic write_capacity(logic [7:0] value);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_capacity(value);
    settings++;
  endtask

  // Keys come from the held set, a shared pool, or fully random values
  task automatic random_request(int unsigned add_pct);
    logic             req;
    logic [KEY_W-1:0] key;
    int unsigned      pick;
    int unsigned      n;
    req  = ($urandom_range(99) < add_pct) ? REQ_ADD : REQ_REMOVE;
    pick = $urandom_range(99);
    n    = board.held_keys.size();
    if (n != 0 && ((req == REQ_ADD && pick < 15) || (req == REQ_REMOVE && pick < 65)))
      key = board.held_keys[$urandom_range(n - 1)];
    else if ((req == REQ_ADD && pick < 55) || (req == REQ_REMOVE && pick < 85))
      key = key_pool[$urandom_range(POOL - 1)];
    else
      key = $urandom();
    send_request(req, key);
  endtask

  task automatic run_phase(logic [7:0] cap, int unsigned add_pct, int unsigned n, bit quiet);
    write_capacity(cap);
    no_stall = quiet;
    repeat (n) random_request(add_pct);
    no_stall = 1'b0;
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL; i++) key_pool[i] = $urandom();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // capacity is zero out of reset: add is full, remove on empty set misses
    send_request(REQ_ADD, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'h0000_0001);

    // small set: fill, duplicate, full over duplicate, remove middle, missing and first
    write_capacity(8'd3);
    send_request(REQ_ADD, 32'h0000_0000);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'hA5A5_A5A5);
    send_request(REQ_ADD, 32'h0000_0000);
    send_request(REQ_ADD, 32'h1234_5678);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'h5A5A_5A5A);
    send_request(REQ_REMOVE, 32'h0000_0000);

    // capacity dropped below the count: adds stay full until removes drain it
    write_capacity(8'd1);
    send_request(REQ_ADD, 32'h0000_0077);
    send_request(REQ_REMOVE, 32'h5A5A_5A5A);
    send_request(REQ_ADD, 32'h0000_0077);
    send_request(REQ_REMOVE, 32'hA5A5_A5A5);
    send_request(REQ_ADD, 32'h0000_0077);
    send_request(REQ_REMOVE, 32'h0000_0077);

    // random phases: fill to the slot limit, then oversize, shrink and zero
    run_phase(8'd128, 90, 350, 1'b0);
    run_phase(8'd255, 55, 150, 1'b0);
    run_phase(8'd5,   50, 150, 1'b0);
    run_phase(8'd0,   40,  80, 1'b0);
    run_phase(8'd1,   60, 100, 1'b0);
    run_phase(8'd64,  60, 200, 1'b1);
    run_phase(8'($urandom_range(255)), 55, 85, 1'b0);
    run_phase(8'($urandom_range(255)), 70, 85, 1'b0);

    // drain
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);

    $display("Covered %0d requests (%0d add, %0d remove) over %0d capacity settings,",
             board.adds + board.removes, board.adds, board.removes, settings);
    $display("status ok %0d, full %0d, duplicate %0d, not found %0d; peak count %0d",
             board.by_status[ST_OK], board.by_status[ST_FULL],
             board.by_status[ST_DUP], board.by_status[ST_NOTFOUND], board.peak);
    if (board.mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
